// ===== src/mccr_pkg.sv =====
// types and constants shared by the midi cc range remapper
package mccr_pkg;

    localparam int ValW    = 7;
    localparam int ChanW   = 4;
    localparam int StatW   = 8;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 7;

    localparam int ProdW   = 16;
    localparam int NumW    = 17;
    localparam int MagW    = 15;
    localparam int DenW    = 8;
    localparam int QuoW    = 7;
    localparam int SumW    = 10;

    localparam logic [StatW-1:0] CC_STATUS = 8'hB0;
    localparam logic [ValW-1:0]  VAL_MAX   = 7'd127;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BLOCK_ALL   = 3'd0,
        REG_PASS_ZERO   = 3'd1,
        REG_PASS_TOP    = 3'd2,
        REG_IN_LOW      = 3'd3,
        REG_IN_HIGH     = 3'd4,
        REG_OUT_LOW     = 3'd5,
        REG_OUT_HIGH    = 3'd6,
        REG_TARGET_CTRL = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [ChanW-1:0] source_channel;
        logic [ValW-1:0]  data_value;
        logic             use_forced;
        logic [ChanW-1:0] forced_channel;
    } msg_beat_t;

    typedef struct packed {
        logic             blocked;
        logic [StatW-1:0] status_byte;
        logic [ValW-1:0]  controller_number;
        logic [ValW-1:0]  mapped_value;
    } result_beat_t;

    // per-item control that rides along the divider
    typedef struct packed {
        logic             blocked;
        logic             direct;
        logic             zero_span;
        logic [ValW-1:0]  value;
        logic [ChanW-1:0] chan;
    } side_t;

    typedef struct packed {
        logic [MagW-1:0] rem;
        logic [DenW-1:0] den;
        logic [QuoW-1:0] quo;
        logic            neg;
        side_t           side;
    } div_t;

endpackage

// ===== src/mccr_stream_if.sv =====
// valid/ready channel carrying one beat of a given payload type
interface mccr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/midi_cc_range_remapper_core.sv =====
// top level of the midi control-change range remapper
// Takes one control-change beat per cycle and returns one result beat per input beat, in
// order, through a decode and multiply stage, a numerator stage, seven divider stages
// that each settle one quotient bit, and the output register. The seven-bit restoring
// divider makes up most of that depth; the throughput is one beat per clock while the
// output side keeps taking results. When the output stalls the whole pipeline holds.
// Configuration registers may be written only while no beat is in flight.
module midi_cc_range_remapper_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mccr_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [mccr_pkg::CfgW-1:0]     cfg_data,
    mccr_stream_if.sink                   msg,
    mccr_stream_if.source                 result
);
    import mccr_pkg::*;

    logic            block_all_reg;
    logic            pass_zero_reg;
    logic            pass_top_reg;
    logic [ValW-1:0] in_low_reg;
    logic [ValW-1:0] in_high_reg;
    logic [ValW-1:0] out_low_reg;
    logic [ValW-1:0] out_high_reg;
    logic [ValW-1:0] target_ctrl_reg;

    logic en;

    // stage 1
    msg_beat_t                beat;
    side_t                    s1_side_next;
    logic signed [ProdW-1:0]  s1_prod_next;
    logic [ValW-1:0]          s1_x;
    logic signed [DenW-1:0]   s1_span_out;
    logic                     s1_ident;
    logic                     s1_valid_reg;
    side_t                    s1_side_reg;
    logic signed [ProdW-1:0]  s1_prod_reg;
    logic [ValW-1:0]          s1_span_reg;

    // stage 2
    logic signed [NumW-1:0]   s2_num;
    div_t                     s2_next;
    logic                     s2_valid_reg;
    div_t                     s2_reg;

    // divider and output
    logic                     dv_valid;
    div_t                     dv_data;
    logic signed [DenW:0]     fin_q;
    logic signed [SumW-1:0]   fin_sum;
    logic [ValW-1:0]          fin_value;
    result_beat_t             result_next;
    logic                     result_valid_reg;
    result_beat_t             result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_all_reg   <= 1'b0;
            pass_zero_reg   <= 1'b1;
            pass_top_reg    <= 1'b1;
            in_low_reg      <= '0;
            in_high_reg     <= VAL_MAX;
            out_low_reg     <= '0;
            out_high_reg    <= VAL_MAX;
            target_ctrl_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BLOCK_ALL:   block_all_reg   <= cfg_data[0];
                REG_PASS_ZERO:   pass_zero_reg   <= cfg_data[0];
                REG_PASS_TOP:    pass_top_reg    <= cfg_data[0];
                REG_IN_LOW:      in_low_reg      <= cfg_data;
                REG_IN_HIGH:     in_high_reg     <= cfg_data;
                REG_OUT_LOW:     out_low_reg     <= cfg_data;
                REG_OUT_HIGH:    out_high_reg    <= cfg_data;
                REG_TARGET_CTRL: target_ctrl_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign en        = !result_valid_reg || result.ready;
    assign msg.ready = en;

    // stage 1: classify the value and form span_out * x
    always_comb
    begin
        beat         = msg.payload;
        s1_ident     = (in_low_reg == '0) && (in_high_reg == VAL_MAX)
                    && (out_low_reg == '0) && (out_high_reg == VAL_MAX);
        s1_x         = beat.data_value - in_low_reg;
        s1_span_out  = $signed({1'b0, out_high_reg}) - $signed({1'b0, out_low_reg});
        s1_prod_next = ProdW'(s1_span_out * $signed({1'b0, s1_x}));

        s1_side_next           = '0;
        s1_side_next.chan      = beat.use_forced ? beat.forced_channel : beat.source_channel;
        s1_side_next.zero_span = (in_low_reg == in_high_reg);
        s1_side_next.value     = beat.data_value;
        if (s1_ident)
        begin
            s1_side_next.direct = 1'b1;
        end
        else if (beat.data_value == '0 && pass_zero_reg)
        begin
            s1_side_next.direct = 1'b1;
        end
        else if (beat.data_value == VAL_MAX && pass_top_reg)
        begin
            s1_side_next.direct = 1'b1;
        end
        else if (beat.data_value < in_low_reg || beat.data_value > in_high_reg)
        begin
            s1_side_next.blocked = 1'b1;
        end
        if (block_all_reg)
        begin
            s1_side_next.blocked = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= msg.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            s1_prod_reg <= s1_prod_next;
            s1_span_reg <= in_high_reg - in_low_reg;
            s2_reg      <= s2_next;
        end
    end

    // stage 2: numerator 2*span_out*x + span_in, split into sign and magnitude
    always_comb
    begin
        s2_num       = (NumW'(s1_prod_reg) <<< 1) + $signed({{(NumW-ValW){1'b0}}, s1_span_reg});
        s2_next      = '0;
        s2_next.neg  = s2_num[NumW-1];
        s2_next.rem  = s2_num[NumW-1] ? MagW'(-s2_num) : MagW'(s2_num);
        s2_next.den  = {s1_span_reg, 1'b0};
        s2_next.side = s1_side_reg;
    end

    mccr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_data   (s2_reg),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    // floor toward minus infinity, add out_low, saturate; direct and zero-span beats skip this
    always_comb
    begin
        fin_q = $signed({2'b00, dv_data.quo});
        if (dv_data.neg)
        begin
            fin_q = -fin_q - $signed({{DenW{1'b0}}, (dv_data.rem != '0)});
        end
        fin_sum = $signed({3'b000, out_low_reg}) + SumW'(fin_q);
        if (dv_data.side.direct)
        begin
            fin_value = dv_data.side.value;
        end
        else if (dv_data.side.zero_span)
        begin
            fin_value = out_low_reg;
        end
        else if (fin_sum < 0)
        begin
            fin_value = '0;
        end
        else if (fin_sum > $signed({3'b000, VAL_MAX}))
        begin
            fin_value = VAL_MAX;
        end
        else
        begin
            fin_value = fin_sum[ValW-1:0];
        end

        result_next = '0;
        if (dv_data.side.blocked)
        begin
            result_next.blocked = 1'b1;
        end
        else
        begin
            result_next.status_byte       = CC_STATUS + {{(StatW-ChanW){1'b0}}, dv_data.side.chan};
            result_next.controller_number = target_ctrl_reg;
            result_next.mapped_value      = fin_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

`ifndef SYNTHESIS
    a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.blocked |->
            result_reg.status_byte == '0 && result_reg.controller_number == '0
            && result_reg.mapped_value == '0)
        else $error("blocked beat carries nonzero fields");

    a_status_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.blocked |-> result_reg.status_byte[7:4] == 4'hB)
        else $error("status byte is not a control change");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && s1_valid_reg |=> s2_valid_reg)
        else $error("beat lost between stage 1 and stage 2");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en && s1_valid_reg |=> s1_valid_reg && $stable(s1_side_reg))
        else $error("stage 1 changed during a stall");
`endif
endmodule

// ===== src/mccr_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module mccr_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  mccr_pkg::div_t in_data,
    output logic           out_valid,
    output mccr_pkg::div_t out_data
);
    import mccr_pkg::*;

    localparam int Steps = QuoW;

    div_t stage_data [Steps+1];
    logic stage_valid [Steps+1];
    div_t data_reg [Steps];
    logic valid_reg [Steps];

    assign stage_data[0]  = in_data;
    assign stage_valid[0] = in_valid;

    for (genvar i = 0; i < Steps; i++) begin : g_step
        localparam int Bit = Steps - 1 - i;
        logic [MagW-1:0] shifted;
        div_t            data_next;

        assign stage_data[i+1]  = data_reg[i];
        assign stage_valid[i+1] = valid_reg[i];

        always_comb
        begin
            shifted   = MagW'(stage_data[i].den) << Bit;
            data_next = stage_data[i];
            if (stage_data[i].rem >= shifted)
            begin
                data_next.rem      = stage_data[i].rem - shifted;
                data_next.quo[Bit] = 1'b1;
            end
            else
            begin
                data_next.quo[Bit] = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= stage_valid[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                data_reg[i] <= data_next;
            end
        end
    end

    assign out_valid = stage_valid[Steps];
    assign out_data  = stage_data[Steps];
endmodule
